// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: sv/mcss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcss_pkg
// types and constants of the coast-down calibration sweep sequencer
// ---------------------------------------------------------------------------
package mcss_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_TICKS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STOP_SPEED    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STILL_SPEED   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRICTION_STEP = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER_STEP    = 3'd5;

    // configuration reset values
    localparam logic [15:0] PULSE_TICKS_RST   = 16'd1000;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd5000;
    localparam logic [15:0] STOP_SPEED_RST    = 16'd655;
    localparam logic [15:0] STILL_SPEED_RST   = 16'd66;
    localparam logic [11:0] FRICTION_STEP_RST = 12'd200;
    localparam logic [9:0]  POWER_STEP_RST    = 10'd250;

    // grid limits in thousandths
    localparam logic signed [12:0] FRICTION_LOW  = -13'sd2000;
    localparam logic signed [13:0] FRICTION_HIGH = 14'sd2000;
    localparam logic [9:0]         POWER_FIRST   = 10'd250;
    localparam logic [10:0]        POWER_HIGH    = 11'd1000;
    localparam logic [9:0]         SAFE_POWER    = 10'd250;

    localparam logic               OP_TICK  = 1'b0;
    localparam logic               OP_START = 1'b1;

    typedef struct packed {
        logic               op;
        logic signed [31:0] speed;
    } tick_item_t;

    typedef struct packed {
        logic               active;
        logic               drive_on;
        logic signed [11:0] friction_factor;
        logic [9:0]         power_factor;
        logic               coasting;
        logic               report_valid;
        logic [15:0]        coast_ticks;
        logic signed [31:0] coast_start_speed;
        logic signed [31:0] peak_speed;
        logic               sweep_done;
    } result_item_t;

endpackage

// File: sv/motor_coastdown_sweep_sequencer_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_coastdown_sweep_sequencer_unit
// coast-down calibration sweep over a friction / power grid
// ---------------------------------------------------------------------------
// usage
//   tick channel (tick_valid / tick_stall / tick) carries one item per control
//   tick: op = start command, or a tick with the filtered Q16.16 speed
//   result channel (result_valid / result_stall / result) returns exactly one
//   item per accepted input item, in order, showing drive request, applied
//   factors, coast measurement and report / sweep-done flags
//   cfg port: cfg_wr_en writes cfg_data into register cfg_index; unused indexes
//   are ignored; the user must write only while the block is idle (unenforced)
// data path
//   an item taken into the input register passes the update logic and is
//   written into the result register once that register is free or being
//   emptied; one item per cycle sustained while result_stall stays low
//   the rate is set by the state update between the two registers
// stall behavior
//   a stalled result holds; the input register still fills, and tick_stall
//   rises only once both registers are full
// reset
//   rst_n clears the sweep state and returns the config registers to their
//   defaults; both channels come up empty
// ---------------------------------------------------------------------------
module motor_coastdown_sweep_sequencer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_valid,
    output logic                                tick_stall,
    input  mcss_pkg::tick_item_t                tick,
    output logic                                result_valid,
    input  logic                                result_stall,
    output mcss_pkg::result_item_t              result,
    input  logic                                cfg_wr_en,
    input  logic [mcss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mcss_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mcss_pkg::*;

    `include "assert_macros.svh"

    // configuration registers
    logic [15:0] pulse_ticks_reg;
    logic [15:0] timeout_ticks_reg;
    logic [15:0] stop_speed_reg;
    logic [15:0] still_speed_reg;
    logic [11:0] friction_step_reg;
    logic [9:0]  power_step_reg;

    // pipeline registers
    logic         s1_valid_reg, s1_valid_next;
    tick_item_t   s1_item_reg;
    logic         result_valid_reg, result_valid_next;
    result_item_t result_reg, result_next;

    // sweep state
    logic               running_reg, running_next;
    logic               pending_reg, pending_next;
    logic [15:0]        pulse_left_reg, pulse_left_next;
    logic               in_coast_reg, in_coast_next;
    logic [15:0]        coast_count_reg, coast_count_next;
    logic signed [31:0] coast_start_reg, coast_start_next;
    logic signed [31:0] speed_peak_reg, speed_peak_next;
    logic signed [12:0] grid_friction_reg, grid_friction_next;
    logic [9:0]         grid_power_reg, grid_power_next;
    logic signed [11:0] applied_friction_reg, applied_friction_next;
    logic [9:0]         applied_power_reg, applied_power_next;
    logic               torque_on_reg, torque_on_next;

    // handshake control
    logic advance;
    logic tick_accept;
    logic s1_fire;

    // result register free or being emptied this cycle
    assign advance     = !result_valid_reg || !result_stall;
    assign tick_stall  = s1_valid_reg && !advance;
    assign tick_accept = tick_valid && !tick_stall;
    assign s1_fire     = s1_valid_reg && advance;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        if (tick_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        result_valid_next = advance ? s1_valid_reg : result_valid_reg;
    end

    // per-item state update, in the order the sequencer rules apply
    always_comb
    begin
        logic [31:0]        spd_u;
        logic [31:0]        mag;
        logic signed [13:0] f_sum;
        logic [10:0]        p_sum;
        logic               report;
        logic               done;

        spd_u = s1_item_reg.speed;
        mag   = spd_u[31] ? (32'd0 - spd_u) : spd_u;
        f_sum = {grid_friction_reg[12], grid_friction_reg} + $signed({2'b00, friction_step_reg});
        p_sum = {1'b0, grid_power_reg} + {1'b0, power_step_reg};

        report                = 1'b0;
        done                  = 1'b0;
        running_next          = running_reg;
        pending_next          = pending_reg;
        pulse_left_next       = pulse_left_reg;
        in_coast_next         = in_coast_reg;
        coast_count_next      = coast_count_reg;
        coast_start_next      = coast_start_reg;
        speed_peak_next       = speed_peak_reg;
        grid_friction_next    = grid_friction_reg;
        grid_power_next       = grid_power_reg;
        applied_friction_next = applied_friction_reg;
        applied_power_next    = applied_power_reg;
        torque_on_next        = torque_on_reg;

        if (s1_item_reg.op == OP_START)
        begin
            // arm current grid point, grid position untouched
            running_next    = 1'b1;
            pending_next    = 1'b1;
            speed_peak_next = '0;
        end
        else if (!running_reg)
        begin
            torque_on_next = 1'b0;
        end
        else
        begin
            // first tick of a grid point: apply factors and start the pulse
            if (pending_reg)
            begin
                pending_next          = 1'b0;
                pulse_left_next       = pulse_ticks_reg;
                torque_on_next        = 1'b1;
                applied_friction_next = grid_friction_reg[11:0];
                applied_power_next    = grid_power_reg;
                in_coast_next         = 1'b0;
                coast_count_next      = '0;
                coast_start_next      = '0;
            end
            if (s1_item_reg.speed > speed_peak_next)
            begin
                speed_peak_next = s1_item_reg.speed;
            end
            // pulse over: release torque and start the coast measurement
            if (pulse_left_next == 16'd0 && !in_coast_next)
            begin
                torque_on_next   = 1'b0;
                coast_count_next = '0;
                coast_start_next = s1_item_reg.speed;
                in_coast_next    = 1'b1;
            end
            if (in_coast_next)
            begin
                if (coast_count_next != 16'hFFFF)
                begin
                    coast_count_next = coast_count_next + 16'd1;
                end
                if (mag < {16'd0, stop_speed_reg} || coast_count_next >= timeout_ticks_reg)
                begin
                    report                = 1'b1;
                    applied_friction_next = '0;
                    applied_power_next    = SAFE_POWER;
                    torque_on_next        = 1'b0;
                    // motor still: step to the next grid point
                    if (mag < {16'd0, still_speed_reg})
                    begin
                        if (f_sum > FRICTION_HIGH)
                        begin
                            grid_friction_next = FRICTION_LOW;
                            if (p_sum > POWER_HIGH)
                            begin
                                running_next    = 1'b0;
                                done            = 1'b1;
                                grid_power_next = POWER_FIRST;
                            end
                            else
                            begin
                                grid_power_next = p_sum[9:0];
                            end
                        end
                        else
                        begin
                            grid_friction_next = f_sum[12:0];
                        end
                        if (!done)
                        begin
                            pending_next    = 1'b1;
                            speed_peak_next = '0;
                        end
                    end
                end
            end
            if (pulse_left_next != 16'd0)
            begin
                pulse_left_next = pulse_left_next - 16'd1;
            end
        end

        result_next.active            = running_next;
        result_next.drive_on          = torque_on_next;
        result_next.friction_factor   = applied_friction_next;
        result_next.power_factor      = applied_power_next;
        result_next.coasting          = in_coast_next;
        result_next.report_valid      = report;
        result_next.coast_ticks       = coast_count_next;
        result_next.coast_start_speed = coast_start_next;
        result_next.peak_speed        = speed_peak_next;
        result_next.sweep_done        = done;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_ticks_reg   <= PULSE_TICKS_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
            stop_speed_reg    <= STOP_SPEED_RST;
            still_speed_reg   <= STILL_SPEED_RST;
            friction_step_reg <= FRICTION_STEP_RST;
            power_step_reg    <= POWER_STEP_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PULSE_TICKS:   pulse_ticks_reg   <= cfg_data;
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data;
                CFG_STOP_SPEED:    stop_speed_reg    <= cfg_data;
                CFG_STILL_SPEED:   still_speed_reg   <= cfg_data;
                CFG_FRICTION_STEP: friction_step_reg <= cfg_data[11:0];
                CFG_POWER_STEP:    power_step_reg    <= cfg_data[9:0];
                default:           ;
            endcase
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            s1_item_reg <= tick;
        end
        if (s1_fire)
        begin
            result_reg <= result_next;
        end
    end

    // sweep state, updated once per item leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg          <= 1'b0;
            pending_reg          <= 1'b0;
            pulse_left_reg       <= '0;
            in_coast_reg         <= 1'b0;
            coast_count_reg      <= '0;
            coast_start_reg      <= '0;
            speed_peak_reg       <= '0;
            grid_friction_reg    <= FRICTION_LOW;
            grid_power_reg       <= POWER_FIRST;
            applied_friction_reg <= '0;
            applied_power_reg    <= SAFE_POWER;
            torque_on_reg        <= 1'b0;
        end
        else if (s1_fire)
        begin
            running_reg          <= running_next;
            pending_reg          <= pending_next;
            pulse_left_reg       <= pulse_left_next;
            in_coast_reg         <= in_coast_next;
            coast_count_reg      <= coast_count_next;
            coast_start_reg      <= coast_start_next;
            speed_peak_reg       <= speed_peak_next;
            grid_friction_reg    <= grid_friction_next;
            grid_power_reg       <= grid_power_next;
            applied_friction_reg <= applied_friction_next;
            applied_power_reg    <= applied_power_next;
            torque_on_reg        <= torque_on_next;
        end
    end

    // checks
    `ASSERT_ALWAYS(a_done_ends_sweep, clk, rst_n,
        !(result_valid_reg && result_reg.sweep_done && result_reg.active),
        "sweep_done reported while sweep still active")
    `ASSERT_ALWAYS(a_report_safe, clk, rst_n,
        !(result_valid_reg && result_reg.report_valid &&
          (result_reg.drive_on || result_reg.friction_factor != 12'sd0)),
        "report without safe factors and released torque")
    `ASSERT_ALWAYS(a_no_drive_in_coast, clk, rst_n,
        !(torque_on_reg && in_coast_reg),
        "torque requested during coast measurement")
    `ASSERT_ALWAYS(a_grid_in_range, clk, rst_n,
        grid_power_reg <= POWER_HIGH[9:0] && grid_power_reg >= POWER_FIRST &&
        grid_friction_reg <= 13'sd2000 && grid_friction_reg >= FRICTION_LOW,
        "grid position out of range")
    `ASSERT_NEXT(a_s1_holds, clk, rst_n,
        s1_valid_reg && !advance, s1_valid_reg,
        "input register dropped an item while blocked")

endmodule

// File: sim/motor_coastdown_sweep_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// motor_coastdown_sweep_sequencer_unit_tb
// self-checking bench for the coast-down calibration sweep sequencer: a short
// directed table (some rows hand-checked), then random phases of sweeps under
// changing register settings, other status compared against a cycle-free predictor
// ---------------------------------------------------------------------------
module motor_coastdown_sweep_sequencer_unit_tb;

    import mcss_pkg::*;

    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam int PHASE_TARGET = 1850;   // non-idle items before the run winds down

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CFG_INDEX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]    data;
        tick_item_t               item;
        bit                       typed;    // status below was worked out by hand
        result_item_t             want;
    } stim_row_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   tick_valid   = 1'b0;
    logic                   tick_stall;
    tick_item_t             tick_bus     = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_item_t           status_bus;
    logic                   cfg_wr_en    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    motor_coastdown_sweep_sequencer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick_bus),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (status_bus),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // register copies held by the predictor
    logic [15:0] cfg_pulse     = PULSE_TICKS_RST;
    logic [15:0] cfg_timeout   = TIMEOUT_TICKS_RST;
    logic [15:0] cfg_stop      = STOP_SPEED_RST;
    logic [15:0] cfg_still     = STILL_SPEED_RST;
    logic [11:0] cfg_fric_step = FRICTION_STEP_RST;
    logic [9:0]  cfg_pow_step  = POWER_STEP_RST;

    // sweep state of the predictor, reset values
    bit                 sw_running     = 1'b0;
    bit                 sw_arm_pending = 1'b0;
    bit                 sw_coasting    = 1'b0;
    bit                 sw_torque      = 1'b0;
    logic [15:0]        sw_pulse_left  = '0;
    logic [15:0]        sw_coast_count = '0;
    logic signed [31:0] sw_coast_start = '0;
    logic signed [31:0] sw_peak        = '0;
    int                 sw_grid_fric   = int'(FRICTION_LOW);
    int                 sw_grid_pow    = int'(POWER_FIRST);
    int                 sw_appl_fric   = 0;
    int                 sw_appl_pow    = int'(SAFE_POWER);

    result_item_t status_due [$];     // status items owed by the block, oldest first
    stim_row_t    directed_rows [$];
    int           mismatches   = 0;
    int           status_seen  = 0;
    bit           gaps_on      = 1'b1;

    // one control tick through the sequencer: returns the status it must report
    function automatic result_item_t predict_status(input tick_item_t it);
        result_item_t       r;
        logic signed [31:0] spd;
        logic [31:0]        mag;
        int                 f;
        int                 p;
        bit                 rep;
        bit                 done;
        rep  = 1'b0;
        done = 1'b0;
        spd  = it.speed;
        if (it.op == OP_START) begin
            // arm the current point, grid position untouched
            sw_running     = 1'b1;
            sw_arm_pending = 1'b1;
            sw_peak        = '0;
        end else if (!sw_running) begin
            sw_torque = 1'b0;
        end else begin
            // magnitude of the most negative speed wraps to 2^31 unsigned
            mag = spd[31] ? (32'd0 - spd) : spd;
            if (sw_arm_pending) begin
                sw_arm_pending = 1'b0;
                sw_pulse_left  = cfg_pulse;
                sw_torque      = 1'b1;
                sw_appl_fric   = sw_grid_fric;
                sw_appl_pow    = sw_grid_pow;
                sw_coasting    = 1'b0;
                sw_coast_count = '0;
                sw_coast_start = '0;
            end
            if (spd > sw_peak)
                sw_peak = spd;
            if (sw_pulse_left == 16'd0 && !sw_coasting) begin
                sw_torque      = 1'b0;
                sw_coast_count = '0;
                sw_coast_start = spd;
                sw_coasting    = 1'b1;
            end
            if (sw_coasting) begin
                if (sw_coast_count != 16'hFFFF)
                    sw_coast_count = sw_coast_count + 16'd1;
                if (mag < {16'd0, cfg_stop} || sw_coast_count >= cfg_timeout) begin
                    rep          = 1'b1;
                    sw_appl_fric = 0;
                    sw_appl_pow  = int'(SAFE_POWER);
                    sw_torque    = 1'b0;
                    if (mag < {16'd0, cfg_still}) begin
                        // next grid point: friction first, then power row
                        f = sw_grid_fric + int'(cfg_fric_step);
                        if (f > int'(FRICTION_HIGH)) begin
                            p = sw_grid_pow + int'(cfg_pow_step);
                            f = int'(FRICTION_LOW);
                            if (p > int'(POWER_HIGH)) begin
                                sw_running = 1'b0;
                                done       = 1'b1;
                                p          = int'(POWER_FIRST);
                            end
                            sw_grid_pow = p;
                        end
                        sw_grid_fric = f;
                        if (!done) begin
                            sw_arm_pending = 1'b1;
                            sw_peak        = '0;
                        end
                    end
                end
            end
            if (sw_pulse_left != 16'd0)
                sw_pulse_left = sw_pulse_left - 16'd1;
        end
        r.active            = sw_running;
        r.drive_on          = sw_torque;
        r.friction_factor   = sw_appl_fric[11:0];
        r.power_factor      = sw_appl_pow[9:0];
        r.coasting          = sw_coasting;
        r.report_valid      = rep;
        r.coast_ticks       = sw_coast_count;
        r.coast_start_speed = sw_coast_start;
        r.peak_speed        = sw_peak;
        r.sweep_done        = done;
        return r;
    endfunction

    function automatic result_item_t mk_status(
        input logic active, input logic drive, input logic signed [11:0] fric,
        input logic [9:0] pow, input logic coast, input logic rep,
        input logic [15:0] ticks, input logic signed [31:0] cstart,
        input logic signed [31:0] peak, input logic done);
        result_item_t r;
        r.active            = active;
        r.drive_on          = drive;
        r.friction_factor   = fric;
        r.power_factor      = pow;
        r.coasting          = coast;
        r.report_valid      = rep;
        r.coast_ticks       = ticks;
        r.coast_start_speed = cstart;
        r.peak_speed        = peak;
        r.sweep_done        = done;
        return r;
    endfunction

    task automatic add_tick(input logic op, input logic [31:0] speed);
        stim_row_t row;
        row       = '{ROW_ITEM, '0, '0, '0, 1'b0, '0};
        row.item  = '{op: op, speed: speed};
        directed_rows.push_back(row);
    endtask

    task automatic add_checked(input logic op, input logic [31:0] speed,
                               input result_item_t want);
        stim_row_t row;
        row       = '{ROW_ITEM, '0, '0, '0, 1'b1, '0};
        row.item  = '{op: op, speed: speed};
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        directed_rows.push_back('{ROW_CFG, idx, data, '0, 1'b0, '0});
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s at status %0d: got %h want %h",
                 what, status_seen, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // sender gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // speeds aimed at the thresholds, so points advance and sweeps finish
    function automatic logic [31:0] pick_speed();
        int roll;
        int lim;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            lim = int'(cfg_still) + 20;
            return $urandom_range(0, 2 * lim) - lim;
        end
        if (roll < 55) begin
            lim = int'(cfg_stop) + 200;
            return $urandom_range(0, 2 * lim) - lim;
        end
        if (roll < 85)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0001;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // present one item, hold it through stalls, predict at the accepting edge
    task automatic push_item(input tick_item_t it, input bit typed,
                             input result_item_t want);
        int           gap;
        result_item_t got_pred;
        gap = pick_gap();
        cfg_wr_en <= 1'b0;
        if (gap > 0) begin
            tick_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_bus   <= it;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        got_pred = predict_status(it);
        status_due.push_back(typed ? want : got_pred);
    endtask

    task automatic drain_results();
        tick_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_PULSE_TICKS:   cfg_pulse     = val;
            CFG_TIMEOUT_TICKS: cfg_timeout   = val;
            CFG_STOP_SPEED:    cfg_stop      = val;
            CFG_STILL_SPEED:   cfg_still     = val;
            CFG_FRICTION_STEP: cfg_fric_step = val[11:0];
            CFG_POWER_STEP:    cfg_pow_step  = val[9:0];
            default: ;
        endcase
    endtask

    // receiver stall: bursts of random length, now and then a calm stretch
    int stall_hold = 0;
    int calm_left  = 0;
    int stall_roll = 0;

    always @(posedge clk) begin
        if (calm_left > 0) begin
            calm_left--;
            result_stall <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 3) begin
                calm_left = $urandom_range(50, 300);
                result_stall <= 1'b0;
            end else if (stall_roll < 5) begin
                stall_hold = $urandom_range(20, 60);
                result_stall <= 1'b1;
            end else if (stall_roll < 35) begin
                stall_hold = $urandom_range(0, 3);
                result_stall <= 1'b1;
            end else begin
                stall_hold = $urandom_range(0, 5);
                result_stall <= 1'b0;
            end
        end
    end

    // status checker: every accepted status against the oldest one due
    result_item_t due_now;

    always @(posedge clk) begin
        if (rst_n && result_valid && !result_stall) begin
            if (status_due.size() == 0) begin
                report_mismatch("status with nothing due", status_bus[31:0], '0);
            end else begin
                due_now = status_due.pop_front();
                check_field("active", 32'(status_bus.active), 32'(due_now.active));
                check_field("drive_on", 32'(status_bus.drive_on),
                            32'(due_now.drive_on));
                check_field("friction_factor", 32'(status_bus.friction_factor),
                            32'(due_now.friction_factor));
                check_field("power_factor", 32'(status_bus.power_factor),
                            32'(due_now.power_factor));
                check_field("coasting", 32'(status_bus.coasting),
                            32'(due_now.coasting));
                check_field("report_valid", 32'(status_bus.report_valid),
                            32'(due_now.report_valid));
                check_field("coast_ticks", 32'(status_bus.coast_ticks),
                            32'(due_now.coast_ticks));
                check_field("coast_start_speed", status_bus.coast_start_speed,
                            due_now.coast_start_speed);
                check_field("peak_speed", status_bus.peak_speed, due_now.peak_speed);
                check_field("sweep_done", 32'(status_bus.sweep_done),
                            32'(due_now.sweep_done));
            end
            status_seen++;
        end
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #20ms;
        $display("motor_coastdown_sweep_sequencer_unit verification failed");
        $finish;
    end

    initial begin
        stim_row_t    row;
        tick_item_t   it;
        logic [15:0]  reg_vals [8];
        int           phase;
        int           phase_items;
        int           sent;
        int           total;
        int           roll;

        // directed table: idle tick and start straight after reset
        add_checked(OP_TICK, 32'd0,
                    mk_status(1'b0, 1'b0, 12'sd0, 10'd250, 1'b0, 1'b0, 16'd0,
                              32'sd0, 32'sd0, 1'b0));
        add_checked(OP_START, 32'h1234_5678,
                    mk_status(1'b1, 1'b0, 12'sd0, 10'd250, 1'b0, 1'b0, 16'd0,
                              32'sd0, 32'sd0, 1'b0));
        // arming tick at full positive speed: pulse on, first grid point applied
        add_checked(OP_TICK, 32'h7FFF_FFFF,
                    mk_status(1'b1, 1'b1, -12'sd2000, 10'd250, 1'b0, 1'b0, 16'd0,
                              32'sd0, 32'sh7FFF_FFFF, 1'b0));
        add_tick(OP_TICK, 32'h8000_0000);
        add_tick(OP_START, 32'hFFFF_FFFF);          // re-arm while running
        // zero-length pulse, coarse grid of two friction points and one row
        add_cfg(CFG_PULSE_TICKS, 16'd0);
        add_cfg(CFG_TIMEOUT_TICKS, 16'd3);
        add_cfg(CFG_STOP_SPEED, 16'd1000);
        add_cfg(CFG_STILL_SPEED, 16'd100);
        add_cfg(CFG_FRICTION_STEP, 16'd4000);
        add_cfg(CFG_POWER_STEP, 16'd1000);
        add_tick(OP_TICK, 32'd5000);                // coasting starts on the arming tick
        add_tick(OP_TICK, 32'h8000_0000);           // most negative speed, large magnitude
        add_tick(OP_TICK, 32'd500);                 // report, but not still yet
        add_tick(OP_TICK, -32'sd50);                // still: on to friction 2000
        // last point: report, grid overflows, sweep finishes
        add_checked(OP_TICK, 32'd0,
                    mk_status(1'b0, 1'b0, 12'sd0, 10'd250, 1'b1, 1'b1, 16'd1,
                              32'sd0, 32'sd0, 1'b1));
        add_tick(OP_TICK, 32'd1234);                // idle tick after the sweep
        // zero steps keep the sweep on one point, zero timeout reports at once
        add_cfg(CFG_FRICTION_STEP, 16'd0);
        add_cfg(CFG_POWER_STEP, 16'd0);
        add_cfg(CFG_TIMEOUT_TICKS, 16'd0);
        add_cfg(CFG_STILL_SPEED, 16'hFFFF);
        add_tick(OP_START, 32'd0);
        add_tick(OP_TICK, 32'd70000);
        add_tick(OP_TICK, 32'd10);
        add_tick(OP_TICK, -32'sd10);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG) begin
                drain_results();
                cfg_write(row.idx, row.data);
            end else begin
                push_item(row.item, row.typed, row.want);
            end
        end

        // random phases: new register settings, then sweeps with random speeds;
        // the first two phases take every register to its top and bottom
        total = 0;
        phase = 0;
        while (total < PHASE_TARGET) begin
            if (phase == 0) begin
                foreach (reg_vals[i]) reg_vals[i] = 16'hFFFF;
            end else if (phase == 1) begin
                foreach (reg_vals[i]) reg_vals[i] = 16'h0000;
            end else begin
                roll = $urandom_range(0, 99);
                reg_vals[CFG_PULSE_TICKS] = (roll < 80) ? 16'($urandom_range(0, 6)) :
                                            (roll < 95) ? 16'($urandom_range(7, 40)) :
                                            16'd1000;
                roll = $urandom_range(0, 99);
                reg_vals[CFG_TIMEOUT_TICKS] = (roll < 10) ? 16'd0 :
                                              (roll < 15) ? 16'hFFFF :
                                              16'($urandom_range(1, 12));
                roll = $urandom_range(0, 99);
                reg_vals[CFG_STOP_SPEED] = (roll < 15) ? 16'hFFFF :
                                           (roll < 25) ? 16'd0 :
                                           16'($urandom_range(0, 3000));
                roll = $urandom_range(0, 99);
                reg_vals[CFG_STILL_SPEED] = (roll < 10) ? 16'd0 :
                                            (roll < 20) ? 16'hFFFF :
                                            16'($urandom_range(0, 400));
                // upper data bits of the narrow steps are dropped by the block
                roll = $urandom_range(0, 99);
                reg_vals[CFG_FRICTION_STEP] = (roll < 10) ? 16'd0 :
                                              (roll < 20) ? 16'($urandom) :
                                              16'($urandom_range(1300, 4095));
                roll = $urandom_range(0, 99);
                reg_vals[CFG_POWER_STEP] = (roll < 10) ? 16'd0 :
                                           (roll < 20) ? 16'($urandom) :
                                           16'($urandom_range(400, 1023));
            end
            reg_vals[CFG_UNUSED_LO] = 16'($urandom);
            reg_vals[CFG_UNUSED_HI] = 16'($urandom);
            gaps_on = ($urandom_range(0, 3) != 0);

            drain_results();
            for (int i = 0; i < 8; i++)
                cfg_write(i[CFG_INDEX_W-1:0], reg_vals[i]);

            phase_items = $urandom_range(60, 200);
            sent = 0;
            while (sent < phase_items) begin
                // mostly ticks into a running sweep, a few stray starts
                if (!sw_running)
                    it.op = ($urandom_range(0, 9) < 8) ? OP_START : OP_TICK;
                else
                    it.op = ($urandom_range(0, 49) == 0) ? OP_START : OP_TICK;
                it.speed = pick_speed();
                // idle ticks do nothing but release torque, so they are not counted
                if (it.op == OP_START || sw_running)
                    sent++;
                push_item(it, 1'b0, '0);
            end
            total += sent;
            phase++;
        end

        drain_results();
        repeat (6) @(posedge clk);
        if (status_due.size() != 0)
            report_mismatch("status items never returned", status_due.size(), '0);

        if (mismatches == 0)
            $display("motor_coastdown_sweep_sequencer_unit verification clean");
        else
            $display("motor_coastdown_sweep_sequencer_unit verification failed");
        $finish;
    end

endmodule
